### rtl/srd_pkg.sv
// ----------------------------------------------------------------------------
// srd_pkg
// Shared types and constants for the stereo reverb ducker.
// ----------------------------------------------------------------------------
package srd_pkg;

	// Register indexes on the configuration port.
	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DUCK_AMOUNT   = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK_COEFF  = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE_COEFF = 2'd2;

	// Coefficient reset values, taken modulo the coefficient width.
	localparam int ATTACK_RESET  = 65263;
	localparam int RELEASE_RESET = 65527;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ENV,
		ST_TGT,
		ST_GAIN,
		ST_DUCK
	} srd_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic prep;
		logic env;
		logic tgt;
		logic gain;
		logic duck;
	} srd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} srd_status_t;

endpackage

### rtl/stereo_reverb_ducker_core.sv
// ----------------------------------------------------------------------------
// stereo_reverb_ducker_core
// Sidechain ducker: the direct signal envelope pushes down the reverb signal.
// ----------------------------------------------------------------------------
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   input    | in_valid / in_stall  | direct_left/right, reverb_left/right
//   output   | out_valid / out_stall| ducked_left/right, applied_gain
//   config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each word passes from acceptance to the output register through coefficient
// select, envelope update, gain target, gain multiply and the scaling step that
// fills the output register. The controller walks one word at a time, so a new
// word is taken while idle or, in the last step, in the same cycle the previous
// result is stored. If the output register is still held by out_stall, the last
// step waits. Reset clears the envelope and loads the default register values;
// configuration writes are always taken.
module stereo_reverb_ducker_core import srd_pkg::*; #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEFF_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [COEFF_BITS:0]           cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] direct_left,
	input  logic signed [SAMPLE_BITS-1:0] direct_right,
	input  logic signed [SAMPLE_BITS-1:0] reverb_left,
	input  logic signed [SAMPLE_BITS-1:0] reverb_right,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] ducked_left,
	output logic signed [SAMPLE_BITS-1:0] ducked_right,
	output logic [COEFF_BITS:0]           applied_gain
);

	logic [COEFF_BITS:0]   duck_amount_q;
	logic [COEFF_BITS-1:0] attack_coeff_q;
	logic [COEFF_BITS-1:0] release_coeff_q;
	srd_cmd_t              cmd;
	srd_status_t           status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duck_amount_q   <= '0;
			attack_coeff_q  <= COEFF_BITS'(ATTACK_RESET);
			release_coeff_q <= COEFF_BITS'(RELEASE_RESET);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DUCK_AMOUNT:   duck_amount_q   <= cfg_data;
				REG_ATTACK_COEFF:  attack_coeff_q  <= cfg_data[COEFF_BITS-1:0];
				REG_RELEASE_COEFF: release_coeff_q <= cfg_data[COEFF_BITS-1:0];
				default: ;
			endcase
		end
	end

	srd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	srd_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEFF_BITS  (COEFF_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.duck_amount   (duck_amount_q),
		.attack_coeff  (attack_coeff_q),
		.release_coeff (release_coeff_q),
		.direct_left   (direct_left),
		.direct_right  (direct_right),
		.reverb_left   (reverb_left),
		.reverb_right  (reverb_right),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.ducked_left   (ducked_left),
		.ducked_right  (ducked_right),
		.applied_gain  (applied_gain)
	);

endmodule

### rtl/srd_ctrl.sv
// ----------------------------------------------------------------------------
// srd_ctrl
// Sequencer that steps one frame through the envelope, gain and scaling steps.
// ----------------------------------------------------------------------------
module srd_ctrl import srd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  srd_status_t status,
	output srd_cmd_t    cmd
);

	srd_state_t state_q;
	srd_state_t state_d;
	logic       take;

	// A new word is taken when idle, or in the last step once its result can be stored.
	assign in_stall = !((state_q == ST_IDLE) || ((state_q == ST_DUCK) && status.out_free));
	assign take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: state_d = ST_ENV;
			ST_ENV:  state_d = ST_TGT;
			ST_TGT:  state_d = ST_GAIN;
			ST_GAIN: state_d = ST_DUCK;
			ST_DUCK: begin
				if (status.out_free) begin
					state_d = take ? ST_PREP : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.load = take;
		unique case (state_q)
			ST_IDLE: ;
			ST_PREP: cmd.prep = 1'b1;
			ST_ENV:  cmd.env  = 1'b1;
			ST_TGT:  cmd.tgt  = 1'b1;
			ST_GAIN: cmd.gain = 1'b1;
			ST_DUCK: cmd.duck = status.out_free;
			default: ;
		endcase
	end

endmodule

### rtl/srd_datapath.sv
// ----------------------------------------------------------------------------
// srd_datapath
// Peak detector, envelope follower, gain computation and wet sample scaling.
// ----------------------------------------------------------------------------
module srd_datapath import srd_pkg::*; #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEFF_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  srd_cmd_t                      cmd,
	output srd_status_t                   status,
	input  logic        [COEFF_BITS:0]    duck_amount,
	input  logic        [COEFF_BITS-1:0]  attack_coeff,
	input  logic        [COEFF_BITS-1:0]  release_coeff,
	input  logic signed [SAMPLE_BITS-1:0] direct_left,
	input  logic signed [SAMPLE_BITS-1:0] direct_right,
	input  logic signed [SAMPLE_BITS-1:0] reverb_left,
	input  logic signed [SAMPLE_BITS-1:0] reverb_right,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] ducked_left,
	output logic signed [SAMPLE_BITS-1:0] ducked_right,
	output logic        [COEFF_BITS:0]    applied_gain
);

	localparam int SB = SAMPLE_BITS;
	localparam int CB = COEFF_BITS;
	localparam int PW = SB + CB + 2;
	localparam int SH_R = (SB > CB) ? SB - CB : 0;
	localparam int SH_L = (SB > CB) ? 0 : CB - SB;
	localparam int RND = (SH_R > 0) ? (1 << ((SH_R > 0) ? SH_R - 1 : 0)) : 0;
	localparam int TW = SB + 3 + SH_L;
	localparam int DUCK_MIN = (1 << CB) / 1000 + 1;
	localparam int GAIN_FLOOR = ((1 << CB) * 5 + 50) / 100;

	localparam logic [CB:0]   ONE  = {1'b1, {CB{1'b0}}};
	localparam logic [CB-1:0] HALF = {1'b1, {(CB-1){1'b0}}};
	localparam logic signed [PW-1:0] SMAX = {{(CB+3){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [PW-1:0] SMIN = {{(CB+3){1'b1}}, {(SB-1){1'b0}}};

	// Rounds w*g/ONE half up and clips it to the sample range.
	function automatic logic signed [SB-1:0] scale_sat(
		input logic signed [SB-1:0] w,
		input logic        [CB:0]   g
	);
		logic signed [PW-1:0] p;
		logic signed [PW-1:0] r;
		p = PW'(w) * PW'($signed({1'b0, g}));
		r = (p + $signed(PW'(HALF))) >>> CB;
		if (r > SMAX) begin
			r = SMAX;
		end else if (r < SMIN) begin
			r = SMIN;
		end
		return r[SB-1:0];
	endfunction

	logic        [SB-1:0] peak_q;
	logic                 duck_on_q;
	logic signed [SB-1:0] rev_l_q;
	logic signed [SB-1:0] rev_r_q;
	logic        [CB-1:0] c_q;
	logic signed [SB:0]   diff_q;
	logic        [SB-1:0] env_q;
	logic        [CB:0]   t_q;
	logic        [CB:0]   g_q;
	logic                 out_valid_q;
	logic signed [SB-1:0] ducked_left_q;
	logic signed [SB-1:0] ducked_right_q;
	logic        [CB:0]   applied_gain_q;

	logic        [CB:0]     amt;
	logic        [SB-1:0]   mag_l;
	logic        [SB-1:0]   mag_r;
	logic signed [PW-1:0]   env_prod;
	logic signed [PW-1:0]   env_sum;
	logic        [SB+2:0]   env5;
	logic        [TW-1:0]   t_wide;
	logic        [TW-1:0]   t_shift;
	logic        [2*CB+1:0] d_prod;
	logic        [CB+1:0]   d_val;
	logic        [CB:0]     g_raw;
	logic                   out_free;

	assign amt   = (duck_amount > ONE) ? ONE : duck_amount;
	assign mag_l = direct_left[SB-1]  ? SB'(-direct_left)  : SB'(direct_left);
	assign mag_r = direct_right[SB-1] ? SB'(-direct_right) : SB'(direct_right);

	// c*env + (ONE-c)*peak is rewritten as peak*ONE + c*(env-peak): one multiply.
	assign env_prod = PW'($signed({1'b0, c_q})) * PW'(diff_q);
	assign env_sum  = $signed({2'b00, peak_q, {CB{1'b0}}}) + env_prod + $signed(PW'(HALF));

	assign env5    = ({3'b000, env_q} << 2) + {3'b000, env_q};
	assign t_wide  = (TW'(env5) << SH_L) + TW'(RND);
	assign t_shift = t_wide >> SH_R;

	assign d_prod = ({{(CB+1){1'b0}}, amt} * {{(CB+1){1'b0}}, t_q}) + (2*CB+2)'(HALF);
	assign d_val  = d_prod[2*CB+1:CB];
	assign g_raw  = (d_val >= {1'b0, ONE}) ? '0 : ONE - d_val[CB:0];

	assign out_free        = !out_valid_q || !out_stall;
	assign status.out_free = out_free;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			peak_q    <= (mag_l > mag_r) ? mag_l : mag_r;
			duck_on_q <= (amt >= (CB+1)'(DUCK_MIN));
			rev_l_q   <= reverb_left;
			rev_r_q   <= reverb_right;
		end
		if (cmd.prep) begin
			c_q    <= (peak_q > env_q) ? attack_coeff : release_coeff;
			diff_q <= $signed({1'b0, env_q}) - $signed({1'b0, peak_q});
		end
		if (cmd.tgt) begin
			t_q <= (t_shift > TW'(ONE)) ? ONE : t_shift[CB:0];
		end
		if (cmd.gain) begin
			if (!duck_on_q) begin
				g_q <= ONE;
			end else if (g_raw < (CB+1)'(GAIN_FLOOR)) begin
				g_q <= (CB+1)'(GAIN_FLOOR);
			end else begin
				g_q <= g_raw;
			end
		end
		if (cmd.duck) begin
			ducked_left_q  <= scale_sat(rev_l_q, g_q);
			ducked_right_q <= scale_sat(rev_r_q, g_q);
			applied_gain_q <= g_q;
		end
	end

	// The envelope only moves while ducking is enabled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.env && duck_on_q) begin
				env_q <= env_sum[SB+CB-1:CB];
			end
			if (cmd.duck) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign ducked_left  = ducked_left_q;
	assign ducked_right = ducked_right_q;
	assign applied_gain = applied_gain_q;

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stereo_reverb_ducker_core. A directed table walks
// the register extremes, the threshold and the out-of-range index, then
// random phases with fresh register settings drive loud and quiet stretches
// of direct signal. Both sides idle and stall at random. Each accepted word
// is predicted by a bit-true model of the envelope follower and gain stage.
// ----------------------------------------------------------------------------
module testbench import srd_pkg::*; ();

	localparam int CLK_PERIOD   = 12;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 250;
	localparam int PHASES       = 10;
	localparam int PHASE_WORDS  = 130;
	localparam int PRINT_LIMIT  = 40;

	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

	localparam longint UNITY      = 65536;
	localparam longint HALF_LSB   = 32768;
	localparam longint GAIN_FLOOR = 3277;
	localparam longint DUCK_MIN   = 66;

	typedef struct packed {
		logic [23:0] left;
		logic [23:0] right;
		logic [16:0] gain;
	} ducked_word_t;

	typedef enum bit {ROW_FRAME, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t                 kind;
		logic [CFG_INDEX_BITS-1:0] reg_index;
		logic [16:0]               reg_value;
		logic [23:0]               dir_l;
		logic [23:0]               dir_r;
		logic [23:0]               rev_l;
		logic [23:0]               rev_r;
		logic                      typed;
		ducked_word_t              want;
	} stim_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [16:0]               cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	logic signed [23:0]        direct_left;
	logic signed [23:0]        direct_right;
	logic signed [23:0]        reverb_left;
	logic signed [23:0]        reverb_right;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [23:0]        ducked_left;
	logic signed [23:0]        ducked_right;
	logic [16:0]               applied_gain;

	// Register shadows and envelope of the predictor.
	logic [16:0]  amount_q;
	logic [15:0]  attack_q;
	logic [15:0]  release_q;
	longint       envelope_q;

	ducked_word_t pending_words[$];
	int           mismatch_count;
	int           results_seen;
	int           words_sent;
	int           settings_seen;
	bit           calm;
	bit           held_off;

	stim_row_t directed_rows [0:24] = '{
		'{ROW_FRAME, REG_UNUSED, 17'd0, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
			1'b1, '{24'h000000, 24'h000000, 17'd65536}},
		'{ROW_FRAME, REG_UNUSED, 17'd0, 24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000,
			1'b1, '{24'h7fffff, 24'h800000, 17'd65536}},
		'{ROW_FRAME, REG_UNUSED, 17'd0, 24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff,
			1'b1, '{24'h800000, 24'h7fffff, 17'd65536}},
		'{ROW_FRAME, REG_UNUSED, 17'd0, 24'h123456, 24'hedcba9, 24'h5a5a5a, 24'ha5a5a5,
			1'b1, '{24'h5a5a5a, 24'ha5a5a5, 17'd65536}},
		'{ROW_WRITE, REG_UNUSED, 17'h1ffff, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_FRAME, REG_UNUSED, 17'd0, 24'h7fffff, 24'h7fffff, 24'h000001, 24'hffffff,
			1'b1, '{24'h000001, 24'hffffff, 17'd65536}},
		'{ROW_WRITE, REG_DUCK_AMOUNT, 17'd65, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_FRAME, REG_UNUSED, 17'd0, 24'h800000, 24'h000000, 24'h400000, 24'hc00000,
			1'b1, '{24'h400000, 24'hc00000, 17'd65536}},
		'{ROW_WRITE, REG_ATTACK_COEFF, 17'd0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_WRITE, REG_RELEASE_COEFF, 17'd0, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_WRITE, REG_DUCK_AMOUNT, 17'h1ffff, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_FRAME, REG_UNUSED, 17'd0, 24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000,
			1'b1, '{24'h066680, 24'hf99980, 17'd3277}},
		'{ROW_FRAME, REG_UNUSED, 17'd0, 24'h000000, 24'h000000, 24'h7fffff, 24'h800000,
			1'b1, '{24'h7fffff, 24'h800000, 17'd65536}},
		'{ROW_WRITE, REG_DUCK_AMOUNT, 17'd66, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_FRAME, REG_UNUSED, 17'd0, 24'h7fffff, 24'h000000, 24'h7fffff, 24'h800000,
			1'b0, '0},
		'{ROW_WRITE, REG_ATTACK_COEFF, 17'h1ffff, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_WRITE, REG_RELEASE_COEFF, 17'h1ffff, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_FRAME, REG_UNUSED, 17'd0, 24'h800000, 24'h800000, 24'h7fffff, 24'h800000,
			1'b0, '0},
		'{ROW_FRAME, REG_UNUSED, 17'd0, 24'h000000, 24'h000000, 24'h3fffff, 24'hc00001,
			1'b0, '0},
		'{ROW_WRITE, REG_DUCK_AMOUNT, 17'h10000, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_WRITE, REG_ATTACK_COEFF, 17'd65263, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_WRITE, REG_RELEASE_COEFF, 17'd65527, 24'h0, 24'h0, 24'h0, 24'h0, 1'b0, '0},
		'{ROW_FRAME, REG_UNUSED, 17'd0, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h800000,
			1'b0, '0},
		'{ROW_FRAME, REG_UNUSED, 17'd0, 24'h000100, 24'hfffe00, 24'h123456, 24'hfedcba,
			1'b0, '0},
		'{ROW_FRAME, REG_UNUSED, 17'd0, 24'h000000, 24'h000000, 24'h7fffff, 24'h800000,
			1'b0, '0}
	};

	stereo_reverb_ducker_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.direct_left  (direct_left),
		.direct_right (direct_right),
		.reverb_left  (reverb_left),
		.reverb_right (reverb_right),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.ducked_left  (ducked_left),
		.ducked_right (ducked_right),
		.applied_gain (applied_gain)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(CLK_PERIOD * 400000);
		$display("** stereo_reverb_ducker_core: FAILED **");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Scales one reverb sample by a Q1.16 gain, rounding half up, saturated.
	function automatic logic [23:0] scale_wet(input logic signed [23:0] wet,
			input longint gain);
		longint prod;
		prod = (longint'(wet) * gain + HALF_LSB) >>> 16;
		if (prod > 8388607)
			prod = 8388607;
		if (prod < -8388608)
			prod = -8388608;
		return prod[23:0];
	endfunction

	// Steps the envelope one frame if ducking is on and returns the ducked word.
	function automatic ducked_word_t duck_frame(input logic signed [23:0] dl, dr, rl, rr);
		longint amt, mag_l, mag_r, peak, coeff, target, depth, gain;
		ducked_word_t word;
		amt = (amount_q > 17'd65536) ? UNITY : longint'(amount_q);
		word.left = rl;
		word.right = rr;
		word.gain = 17'd65536;
		if (amt >= DUCK_MIN) begin
			mag_l = (longint'(dl) < 0) ? -longint'(dl) : longint'(dl);
			mag_r = (longint'(dr) < 0) ? -longint'(dr) : longint'(dr);
			peak = (mag_l > mag_r) ? mag_l : mag_r;
			coeff = (peak > envelope_q) ? longint'(attack_q) : longint'(release_q);
			envelope_q = (coeff * envelope_q + (UNITY - coeff) * peak + HALF_LSB) >> 16;
			target = (envelope_q * 5 + 128) >> 8;
			if (target > UNITY)
				target = UNITY;
			depth = (amt * target + HALF_LSB) >> 16;
			gain = (depth >= UNITY) ? 0 : UNITY - depth;
			if (gain < GAIN_FLOOR)
				gain = GAIN_FLOOR;
			word.left = scale_wet(rl, gain);
			word.right = scale_wet(rr, gain);
			word.gain = gain[16:0];
		end
		return word;
	endfunction

	// Lets the block run dry so that a register write cannot touch a word.
	task automatic settle_block();
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index, input logic [16:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (index)
			REG_DUCK_AMOUNT:   amount_q = value;
			REG_ATTACK_COEFF:  attack_q = value[15:0];
			REG_RELEASE_COEFF: release_q = value[15:0];
			default: ;
		endcase
	endtask

	task automatic send_frame(input logic [23:0] dl, dr, rl, rr,
			input bit typed, input ducked_word_t typed_word);
		ducked_word_t want;
		cfg_valid <= 1'b0;
		while (!calm && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		direct_left <= dl;
		direct_right <= dr;
		reverb_left <= rl;
		reverb_right <= rr;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		want = duck_frame(dl, dr, rl, rr);
		pending_words.push_back(typed ? typed_word : want);
		words_sent++;
	endtask

	function automatic logic [23:0] direct_sample(input int loudness);
		int unsigned r;
		r = $urandom();
		case (loudness)
			0: return 24'd0;
			1: return 24'(int'(r % 2047) - 1023);
			2: return 24'(int'(r % 524287) - 262143);
			default: begin
				if (r[31:27] == 5'd0)
					return r[26] ? 24'h800000 : 24'h7fffff;
				return r[23:0];
			end
		endcase
	endfunction

	function automatic logic [16:0] pick_amount();
		case ($urandom_range(8))
			0: return 17'd0;
			1: return 17'd65;
			2: return 17'd66;
			3: return 17'd65536;
			4: return 17'($urandom_range(131071, 65537));
			default: return 17'($urandom_range(65535, 66));
		endcase
	endfunction

	function automatic logic [16:0] pick_coeff();
		case ($urandom_range(5))
			0: return 17'd0;
			1: return 17'h1ffff;
			2: return 17'($urandom_range(65535, 65000));
			3: return 17'($urandom());
			default: return 17'($urandom_range(65000, 30000));
		endcase
	endfunction

	// Receiver: random stalls, a calm stretch, and one long hold-off that
	// backs the pipeline up into the input.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!held_off && results_seen >= 400) begin
				held_off = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= !calm && ($urandom_range(99) < 37);
		end
	end

	always @(posedge clk) begin : check_words
		ducked_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_words.size() == 0) begin
				report_mismatch("result word with nothing pending");
			end else begin
				want = pending_words.pop_front();
				if (ducked_left !== want.left)
					report_mismatch($sformatf("ducked_left got %0d want %0d",
						ducked_left, $signed(want.left)));
				if (ducked_right !== want.right)
					report_mismatch($sformatf("ducked_right got %0d want %0d",
						ducked_right, $signed(want.right)));
				if (applied_gain !== want.gain)
					report_mismatch($sformatf("applied_gain got %0d want %0d",
						applied_gain, want.gain));
			end
		end
	end

	initial begin : stimulus
		int stretch_left;
		int loudness;
		int drain_wait;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_DUCK_AMOUNT;
		cfg_data = 17'd0;
		in_valid = 1'b0;
		direct_left = 24'd0;
		direct_right = 24'd0;
		reverb_left = 24'd0;
		reverb_right = 24'd0;
		amount_q = 17'd0;
		attack_q = 16'(ATTACK_RESET);
		release_q = 16'(RELEASE_RESET);
		envelope_q = 0;
		mismatch_count = 0;
		results_seen = 0;
		words_sent = 0;
		settings_seen = 1;
		calm = 1'b0;
		held_off = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				settle_block();
				write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
				settings_seen++;
			end else begin
				send_frame(directed_rows[i].dir_l, directed_rows[i].dir_r,
					directed_rows[i].rev_l, directed_rows[i].rev_r,
					directed_rows[i].typed, directed_rows[i].want);
			end
		end

		stretch_left = 0;
		loudness = 0;
		for (int phase = 0; phase < PHASES; phase++) begin
			settle_block();
			calm = (phase == 1);
			write_reg(REG_ATTACK_COEFF, pick_coeff());
			write_reg(REG_RELEASE_COEFF, pick_coeff());
			if ($urandom_range(2) == 0)
				write_reg(REG_UNUSED, 17'($urandom()));
			write_reg(REG_DUCK_AMOUNT, (phase == 0) ? 17'd65536 : pick_amount());
			settings_seen++;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// Loud bursts and quiet stretches make the envelope rise and fall.
				if (stretch_left == 0) begin
					stretch_left = $urandom_range(60, 4);
					loudness = $urandom_range(3);
				end
				stretch_left--;
				send_frame(direct_sample(loudness), direct_sample(loudness),
					24'($urandom()), 24'($urandom()), 1'b0, '0);
			end
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		drain_wait = 0;
		while (pending_words.size() != 0 && drain_wait < 20000) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (DRAIN_CYCLES * 2) @(posedge clk);
		if (pending_words.size() != 0)
			report_mismatch($sformatf("%0d words never came out", pending_words.size()));

		$display("Sent %0d stereo words under %0d register settings, %0d results checked,",
			words_sent, settings_seen, results_seen);
		$display("with random idling on both sides and a %0d-cycle output hold-off.",
			HOLD_CYCLES);
		if (mismatch_count == 0) begin
			$display("** stereo_reverb_ducker_core: PASSED **");
		end else begin
			$display("** stereo_reverb_ducker_core: FAILED **");
		end
		$finish;
	end

endmodule
